// ===== src/pstc_pkg.sv =====
// Shared types and constants for the pressure/temperature compensation block.
// Used by every module under src; depends on nothing else.
package pstc_pkg;

    // Field widths of the stream payloads.
    localparam int RAW_W       = 24;
    localparam int TEMP_W      = 19;
    localparam int PRES_W      = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register stages in the datapath, the last one being the output register.
    localparam int PIPE_STAGES = 9;

    typedef logic [PIPE_STAGES-1:0] stage_vec_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROM_WORD0        = 3'd0,
        REG_SENS_COEFF        = 3'd1,
        REG_OFFSET_COEFF      = 3'd2,
        REG_SENS_TEMP_COEFF   = 3'd3,
        REG_OFFSET_TEMP_COEFF = 3'd4,
        REG_REF_TEMP          = 3'd5,
        REG_TEMP_COEFF        = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        CRC_IDLE = 1'b0,
        CRC_RUN  = 1'b1
    } crc_state_t;

    // Calibration coefficients handed to the datapath.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] sens;       // C1
        logic [CFG_DATA_W-1:0] off;        // C2
        logic [CFG_DATA_W-1:0] sens_tc;    // C3
        logic [CFG_DATA_W-1:0] off_tc;     // C4
        logic [CFG_DATA_W-1:0] tref;       // C5
        logic [CFG_DATA_W-1:0] tc;         // C6
    } cal_t;

endpackage

// ===== src/pstc_cfg.sv =====
// Calibration register file and the byte-serial CRC check of its contents.
// Depends on pstc_pkg.
module pstc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pstc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pstc_pkg::CFG_DATA_W-1:0] cfg_data,
    output pstc_pkg::cal_t                 cal,
    output logic                           crc_bad,
    output logic                           crc_busy
);
    import pstc_pkg::*;

    localparam int          CRC_BYTES = 16;
    localparam logic [15:0] CRC_POLY  = 16'h3000;
    localparam logic [15:0] DATA_MASK = 16'h0FFF;

    logic [CFG_DATA_W-1:0] prom0_reg;
    logic [CFG_DATA_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    crc_state_t  crc_state_reg, crc_state_next;
    logic [3:0]  byte_cnt_reg, byte_cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic        crc_bad_reg, crc_bad_next;

    logic [15:0] crc_word;
    logic [7:0]  crc_byte;
    logic [15:0] rem_step;

    // One message byte folded into the remainder, eight bit steps.
    function automatic logic [15:0] crc_fold(input logic [15:0] rem_in,
                                             input logic [7:0]  data);
        logic [15:0] r;
        r = rem_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (r[15])
            begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prom0_reg <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            c4_reg    <= '0;
            c5_reg    <= '0;
            c6_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_PROM_WORD0:        prom0_reg <= cfg_data;
                REG_SENS_COEFF:        c1_reg    <= cfg_data;
                REG_OFFSET_COEFF:      c2_reg    <= cfg_data;
                REG_SENS_TEMP_COEFF:   c3_reg    <= cfg_data;
                REG_OFFSET_TEMP_COEFF: c4_reg    <= cfg_data;
                REG_REF_TEMP:          c5_reg    <= cfg_data;
                REG_TEMP_COEFF:        c6_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // The eighth word of the CRC message is zero.
    always_comb
    begin
        case (cfg_idx_t'(byte_cnt_reg[3:1]))
            REG_PROM_WORD0:        crc_word = prom0_reg & DATA_MASK;
            REG_SENS_COEFF:        crc_word = c1_reg;
            REG_OFFSET_COEFF:      crc_word = c2_reg;
            REG_SENS_TEMP_COEFF:   crc_word = c3_reg;
            REG_OFFSET_TEMP_COEFF: crc_word = c4_reg;
            REG_REF_TEMP:          crc_word = c5_reg;
            REG_TEMP_COEFF:        crc_word = c6_reg;
            default:               crc_word = '0;
        endcase
        crc_byte = byte_cnt_reg[0] ? crc_word[7:0] : crc_word[15:8];
        rem_step = crc_fold(rem_reg, crc_byte);
    end

    // Next state and counters; any write restarts the pass.
    always_comb
    begin
        crc_state_next = crc_state_reg;
        byte_cnt_next  = byte_cnt_reg;
        rem_next       = rem_reg;
        crc_bad_next   = crc_bad_reg;
        case (crc_state_reg)
            CRC_IDLE:
            begin
                if (cfg_we)
                begin
                    crc_state_next = CRC_RUN;
                    byte_cnt_next  = '0;
                    rem_next       = '0;
                end
            end
            CRC_RUN:
            begin
                if (cfg_we)
                begin
                    byte_cnt_next = '0;
                    rem_next      = '0;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                    rem_next      = rem_step;
                    if (byte_cnt_reg == 4'(CRC_BYTES - 1))
                    begin
                        crc_state_next = CRC_IDLE;
                        crc_bad_next   = rem_step[15:12] != prom0_reg[15:12];
                    end
                end
            end
            default:
            begin
                crc_state_next = CRC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (crc_state_reg)
            CRC_RUN: crc_busy = 1'b1;
            default: crc_busy = 1'b0;
        endcase
    end

    // All-zero calibration words give a zero CRC, which matches the reset nibble.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_state_reg <= CRC_IDLE;
            byte_cnt_reg  <= '0;
            rem_reg       <= '0;
            crc_bad_reg   <= 1'b0;
        end
        else
        begin
            crc_state_reg <= crc_state_next;
            byte_cnt_reg  <= byte_cnt_next;
            rem_reg       <= rem_next;
            crc_bad_reg   <= crc_bad_next;
        end
    end

    assign cal.sens    = c1_reg;
    assign cal.off     = c2_reg;
    assign cal.sens_tc = c3_reg;
    assign cal.off_tc  = c4_reg;
    assign cal.tref    = c5_reg;
    assign cal.tc      = c6_reg;
    assign crc_bad     = crc_bad_reg;

endmodule

// ===== src/pstc_ctrl.sv =====
// Valid bits and stage enables of the datapath pipeline.
// A stage moves when it is empty or when the stage after it moves. Depends on pstc_pkg.
module pstc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 out_ready,
    output pstc_pkg::stage_vec_t en,
    output logic                 out_valid
);
    import pstc_pkg::*;

    stage_vec_t vld_reg, vld_next;

    always_comb
    begin
        en[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next[0] = en[0] ? in_fire : vld_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[PIPE_STAGES-1];

endmodule

// ===== src/pstc_dp.sv =====
// Nine-stage compensation datapath: first order terms, second order corrections,
// pressure product split in two partial products, rounding and limits. Depends on pstc_pkg.
module pstc_dp #(
    parameter int ADC_BITS = 24
) (
    input  logic                           clk,
    input  pstc_pkg::stage_vec_t           en,
    input  logic [pstc_pkg::RAW_W-1:0]     raw_pressure,
    input  logic [pstc_pkg::RAW_W-1:0]     raw_temperature,
    input  pstc_pkg::cal_t                 cal,
    input  logic                           crc_bad_in,
    output logic signed [pstc_pkg::TEMP_W-1:0] temp_centi,
    output logic signed [pstc_pkg::PRES_W-1:0] pressure_centi,
    output logic                           crc_bad,
    output logic                           out_of_range
);
    import pstc_pkg::*;

    localparam int D1_W   = ADC_BITS;
    localparam int DT_W   = RAW_W + 1;
    localparam int MUL_W  = DT_W + CFG_DATA_W + 1;
    localparam int DSQ_W  = 2 * RAW_W + 1;
    localparam int T_W    = 20;
    localparam int OFF_W  = 36;
    localparam int SENS_W = 35;
    localparam int SQ_W   = 36;
    localparam int CORR_W = 42;
    localparam int OFFC_W = 43;
    localparam int SC_W   = 40;
    localparam int HALF_W = SC_W / 2;
    localparam int PPL_W  = D1_W + HALF_W;
    localparam int PPH_W  = D1_W + HALF_W + 1;
    localparam int PROD_W = 64;
    localparam int R_W    = 44;

    // stage 0
    logic signed [DT_W-1:0]  dt_reg, dt_next;
    logic [RAW_W-1:0]        d2_masked;
    logic [D1_W-1:0]         d1_reg [0:4];
    // stage 1
    logic signed [MUL_W-1:0] mt_reg, mt_next, mo_reg, mo_next, ms_reg, ms_next;
    logic signed [DSQ_W:0]   dsq_w;
    logic [DSQ_W-1:0]        dsq_reg, dsq_next;
    // stage 2
    logic signed [MUL_W-1:0] mt_b, mt_q, mo_b, mo_q, ms_b, ms_q;
    logic [DSQ_W+1:0]        sum5;
    logic [DSQ_W:0]          sum3;
    logic signed [T_W-1:0]   temp_reg, temp_next;
    logic signed [OFF_W-1:0] off_reg, off_next, off3_reg;
    logic signed [SENS_W-1:0] sens_reg, sens_next, sens3_reg;
    logic [12:0]             t2hi_reg, t2hi_next;
    logic [16:0]             t2lo_reg, t2lo_next;
    // stage 3
    logic signed [T_W:0]     dm, ep;
    logic signed [2*T_W+1:0] dm_sq, ep_sq;
    logic [SQ_W-1:0]         dsq2_reg, dsq2_next, esq_reg, esq_next;
    logic                    low_reg, low_next, vlow_reg, vlow_next;
    logic signed [T_W-1:0]   tout_reg [0:4];
    logic signed [T_W-1:0]   tout_next;
    // stage 4
    logic [CORR_W-1:0]       m61, m29, e17, e9, off2, sens2;
    logic signed [OFFC_W-1:0] offc_next, sensc_w;
    logic signed [OFFC_W-1:0] offc_reg [0:2];
    logic signed [SC_W-1:0]  sensc_reg, sensc_next;
    // stage 5
    logic [PPL_W-1:0]        pp_lo_reg, pp_lo_next;
    logic signed [PPH_W-1:0] pp_hi_reg, pp_hi_next;
    // stage 6
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    // stage 7
    logic signed [PROD_W-1:0] prod_b, prod_q;
    logic signed [R_W-1:0]   r_reg, r_next;
    // stage 8
    logic signed [R_W-1:0]   r_b, p_full;
    logic signed [TEMP_W-1:0] temp_out_reg, temp_out_next;
    logic signed [PRES_W-1:0] pres_out_reg, pres_out_next;
    logic                    crc_out_reg;
    logic                    oor_reg, oor_next;

    // Stage 0: temperature difference against the reference.
    always_comb
    begin
        d2_masked = RAW_W'(raw_temperature[D1_W-1:0]);
        dt_next   = $signed({1'b0, d2_masked}) - $signed({1'b0, cal.tref, 8'h00});
    end

    // Stage 1: products with the raw temperature difference.
    always_comb
    begin
        mt_next  = dt_reg * $signed({1'b0, cal.tc});
        mo_next  = dt_reg * $signed({1'b0, cal.off_tc});
        ms_next  = dt_reg * $signed({1'b0, cal.sens_tc});
        dsq_w    = dt_reg * dt_reg;
        dsq_next = dsq_w[DSQ_W-1:0];
    end

    // Stage 2: divisions truncate toward zero, so negative values get a bias first.
    always_comb
    begin
        mt_b = mt_reg + (mt_reg[MUL_W-1] ? MUL_W'(64'h7F_FFFF) : '0);
        mt_q = mt_b >>> 23;
        mo_b = mo_reg + (mo_reg[MUL_W-1] ? MUL_W'(64'h3F) : '0);
        mo_q = mo_b >>> 6;
        ms_b = ms_reg + (ms_reg[MUL_W-1] ? MUL_W'(64'h7F) : '0);
        ms_q = ms_b >>> 7;

        temp_next = mt_q[T_W-1:0] + T_W'(2000);
        off_next  = OFF_W'({cal.off, 17'h0}) + mo_q[OFF_W-1:0];
        sens_next = SENS_W'({cal.sens, 16'h0}) + ms_q[SENS_W-1:0];

        sum5      = (DSQ_W+2)'({dsq_reg, 2'b00}) + (DSQ_W+2)'(dsq_reg);
        sum3      = (DSQ_W+1)'({dsq_reg, 1'b0}) + (DSQ_W+1)'(dsq_reg);
        t2hi_next = sum5[DSQ_W+1:38];
        t2lo_next = sum3[DSQ_W:33];
    end

    // Stage 3: squares for the low-temperature corrections, corrected temperature.
    always_comb
    begin
        dm        = (T_W+1)'(temp_reg) - (T_W+1)'(2000);
        ep        = (T_W+1)'(temp_reg) + (T_W+1)'(1500);
        dm_sq     = dm * dm;
        ep_sq     = ep * ep;
        dsq2_next = dm_sq[SQ_W-1:0];
        esq_next  = ep_sq[SQ_W-1:0];
        low_next  = temp_reg < $signed(T_W'(2000));
        vlow_next = temp_reg < -$signed(T_W'(1500));
        tout_next = temp_reg - (low_next ? T_W'(t2lo_reg) : T_W'(t2hi_reg));
    end

    // Stage 4: second order offset and sensitivity, applied to the first order terms.
    always_comb
    begin
        m61   = CORR_W'({dsq2_reg, 6'b0}) - CORR_W'({dsq2_reg, 1'b0}) - CORR_W'(dsq2_reg);
        m29   = CORR_W'({dsq2_reg, 5'b0}) - CORR_W'({dsq2_reg, 1'b0}) - CORR_W'(dsq2_reg);
        e17   = CORR_W'({esq_reg, 4'b0}) + CORR_W'(esq_reg);
        e9    = CORR_W'({esq_reg, 3'b0}) + CORR_W'(esq_reg);
        off2  = '0;
        sens2 = '0;
        if (low_reg)
        begin
            off2  = CORR_W'(m61[CORR_W-1:4]) + (vlow_reg ? e17 : '0);
            sens2 = CORR_W'(m29[CORR_W-1:4]) + (vlow_reg ? e9 : '0);
        end
        offc_next  = OFFC_W'(off3_reg) - $signed({1'b0, off2});
        sensc_w    = OFFC_W'(sens3_reg) - $signed({1'b0, sens2});
        sensc_next = sensc_w[SC_W-1:0];
    end

    // Stage 5: D1 times the sensitivity as two partial products.
    always_comb
    begin
        pp_lo_next = d1_reg[4] * sensc_reg[HALF_W-1:0];
        pp_hi_next = $signed({1'b0, d1_reg[4]}) * $signed(sensc_reg[SC_W-1:HALF_W]);
    end

    // Stage 6: recombine the partial products.
    always_comb
    begin
        prod_next = (PROD_W'(pp_hi_reg) <<< HALF_W) + PROD_W'(pp_lo_reg);
    end

    // Stage 7: scale by 2^21 and remove the offset.
    always_comb
    begin
        prod_b = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'(64'h1F_FFFF) : '0);
        prod_q = prod_b >>> 21;
        r_next = prod_q[R_W-1:0] - R_W'(offc_reg[2]);
    end

    // Stage 8: scale by 2^15, range check and saturation. The pressure stays
    // within 29 bits, so only the temperature can need clamping.
    always_comb
    begin
        r_b    = r_reg + (r_reg[R_W-1] ? R_W'(64'h7FFF) : '0);
        p_full = r_b >>> 15;

        oor_next = (tout_reg[4] < -$signed(T_W'(4000)))
                || (tout_reg[4] > $signed(T_W'(8500)))
                || (p_full < $signed(R_W'(1000)))
                || (p_full > $signed(R_W'(200000)));

        if (tout_reg[4] > $signed(T_W'(262143)))
        begin
            temp_out_next = TEMP_W'(262143);
        end
        else if (tout_reg[4] < -$signed(T_W'(262144)))
        begin
            temp_out_next = TEMP_W'(262144);
        end
        else
        begin
            temp_out_next = tout_reg[4][TEMP_W-1:0];
        end
        pres_out_next = p_full[PRES_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt_reg    <= dt_next;
            d1_reg[0] <= raw_pressure[D1_W-1:0];
        end
        if (en[1])
        begin
            mt_reg    <= mt_next;
            mo_reg    <= mo_next;
            ms_reg    <= ms_next;
            dsq_reg   <= dsq_next;
            d1_reg[1] <= d1_reg[0];
        end
        if (en[2])
        begin
            temp_reg  <= temp_next;
            off_reg   <= off_next;
            sens_reg  <= sens_next;
            t2hi_reg  <= t2hi_next;
            t2lo_reg  <= t2lo_next;
            d1_reg[2] <= d1_reg[1];
        end
        if (en[3])
        begin
            dsq2_reg    <= dsq2_next;
            esq_reg     <= esq_next;
            low_reg     <= low_next;
            vlow_reg    <= vlow_next;
            tout_reg[0] <= tout_next;
            off3_reg    <= off_reg;
            sens3_reg   <= sens_reg;
            d1_reg[3]   <= d1_reg[2];
        end
        if (en[4])
        begin
            offc_reg[0] <= offc_next;
            sensc_reg   <= sensc_next;
            tout_reg[1] <= tout_reg[0];
            d1_reg[4]   <= d1_reg[3];
        end
        if (en[5])
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            offc_reg[1] <= offc_reg[0];
            tout_reg[2] <= tout_reg[1];
        end
        if (en[6])
        begin
            prod_reg    <= prod_next;
            offc_reg[2] <= offc_reg[1];
            tout_reg[3] <= tout_reg[2];
        end
        if (en[7])
        begin
            r_reg       <= r_next;
            tout_reg[4] <= tout_reg[3];
        end
        if (en[8])
        begin
            temp_out_reg <= temp_out_next;
            pres_out_reg <= pres_out_next;
            crc_out_reg  <= crc_bad_in;
            oor_reg      <= oor_next;
        end
    end

    assign temp_centi     = temp_out_reg;
    assign pressure_centi = pres_out_reg;
    assign crc_bad        = crc_out_reg;
    assign out_of_range   = oor_reg;

endmodule

// ===== src/pressure_temp_compensation.sv =====
// Top level of the barometric pressure/temperature compensation block.
// Instantiates pstc_cfg, pstc_ctrl and pstc_dp; depends on pstc_pkg.
//
//   port group   direction  item
//   s_axis_*     in         raw pressure and raw temperature conversion pair
//   m_axis_*     out        compensated temperature and pressure, CRC and range flags
//   cfg_*        in         write of one calibration register
//
// One item enters per clock while s_axis_tready is high; a result passes through
// the nine register stages of the datapath, the last being the output register.
// Reset clears the calibration registers and all pipeline valid bits.
// A stalled output holds the pipeline in place; empty stages still fill.
// After each configuration write the calibration CRC is recomputed one byte per
// cycle over 16 bytes (a further write restarts it); s_axis_tready stays low during that pass.
module pressure_temp_compensation #(
    parameter int ADC_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pstc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pstc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // raw_pressure [23:0], raw_temperature [47:24]
    input  logic [pstc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // temp_centi [18:0], pressure_centi [50:19], zero [55:51]
    output logic [pstc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // crc_bad [0], out_of_range [1]
    output logic [pstc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import pstc_pkg::*;

    cal_t                     cal;
    logic                     crc_bad_cfg;
    logic                     crc_busy;
    stage_vec_t               en;
    logic                     in_fire;
    logic signed [TEMP_W-1:0] temp_centi;
    logic signed [PRES_W-1:0] pressure_centi;
    logic                     crc_bad;
    logic                     out_of_range;

    pstc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal),
        .crc_bad   (crc_bad_cfg),
        .crc_busy  (crc_busy)
    );

    assign s_axis_tready = en[0] && !crc_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    pstc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_ready (m_axis_tready),
        .en        (en),
        .out_valid (m_axis_tvalid)
    );

    pstc_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk             (clk),
        .en              (en),
        .raw_pressure    (s_axis_tdata[RAW_W-1:0]),
        .raw_temperature (s_axis_tdata[2*RAW_W-1:RAW_W]),
        .cal             (cal),
        .crc_bad_in      (crc_bad_cfg),
        .temp_centi      (temp_centi),
        .pressure_centi  (pressure_centi),
        .crc_bad         (crc_bad),
        .out_of_range    (out_of_range)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - TEMP_W - PRES_W)'(0), pressure_centi, temp_centi};
    assign m_axis_tuser = {out_of_range, crc_bad};

endmodule
